// ===== hdl/xeu_pkg.sv =====
// Shared types and constants for the XML entity unescaper.
// Holds the entity spelling table, sizes and the decode result struct.
// No dependencies.
package xeu_pkg;

  localparam int unsigned NUM_ENT  = 5;  // predefined entities
  localparam int unsigned HOLD_MAX = 5;  // longest held prefix
  localparam int unsigned ENT_MAX  = 6;  // longest entity spelling
  localparam int unsigned RES_MAX  = 6;  // most results from one request

  localparam logic [7:0] AMP = 8'h26;    // '&'

  // Entity spellings, padded with zero bytes; byte 0 of each is the ampersand
  localparam logic [0:NUM_ENT-1][0:ENT_MAX-1][7:0] ENT_TEXT = '{
    '{8'h26, 8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00},  // &lt;
    '{8'h26, 8'h67, 8'h74, 8'h3b, 8'h00, 8'h00},  // &gt;
    '{8'h26, 8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00},  // &amp;
    '{8'h26, 8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b},  // &quot;
    '{8'h26, 8'h61, 8'h70, 8'h6f, 8'h73, 8'h3b}   // &apos;
  };

  localparam logic [0:NUM_ENT-1][3:0] ENT_LEN = '{4'd4, 4'd4, 4'd5, 4'd6, 4'd6};

  localparam logic [0:NUM_ENT-1][7:0] ENT_REPL = '{8'h3c, 8'h3e, 8'h26, 8'h22, 8'h27};

  // Outcome of decoding one request against the held prefix
  typedef struct packed {
    logic [2:0]                  held_count;
    logic [HOLD_MAX-1:0][7:0]    held_bytes;
    logic [2:0]                  res_count;
    logic [RES_MAX-1:0][7:0]     res_bytes;
  } dec_t;

endpackage

// ===== hdl/xeu_if.sv =====
// Valid/ready stream interfaces for the XML entity unescaper.
// One for escaped input bytes, one for decoded output bytes.
// No dependencies.
interface xeu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface xeu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       text_done;

  modport source (output valid, output out_byte, output run_last, output text_done,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input text_done,
                  output ready);
endinterface

// ===== hdl/xeu_decode.sv =====
// Combinational entity match for one request against the held prefix.
// Depends on xeu_pkg for the entity table and the dec_t result struct.
module xeu_decode (
  input  logic [2:0]                        held_count_i,
  input  logic [xeu_pkg::HOLD_MAX-1:0][7:0] held_bytes_i,
  input  logic [7:0]                        in_byte_i,
  input  logic                              eot_i,
  output xeu_pkg::dec_t                     dec_o
);

  logic [xeu_pkg::ENT_MAX-1:0][7:0] cand;
  logic [xeu_pkg::NUM_ENT-1:0]      ent_match;
  logic [xeu_pkg::NUM_ENT-1:0]      ent_full;
  logic [7:0]                       repl;
  logic [3:0]                       cand_len;
  logic                             any_full;
  logic                             extend;

  assign cand_len = {1'b0, held_count_i} + 4'd1;

  // Candidate: held bytes followed by the new byte
  always_comb begin
    for (int i = 0; i < xeu_pkg::ENT_MAX; i++) begin
      if (3'(i) < held_count_i && i < xeu_pkg::HOLD_MAX) begin
        cand[i] = held_bytes_i[i];
      end else if (3'(i) == held_count_i) begin
        cand[i] = in_byte_i;
      end else begin
        cand[i] = 8'h00;
      end
    end
  end

  // Prefix and full match against each entity
  always_comb begin
    for (int e = 0; e < xeu_pkg::NUM_ENT; e++) begin
      ent_match[e] = (cand_len <= xeu_pkg::ENT_LEN[e]);
      for (int i = 0; i < xeu_pkg::ENT_MAX; i++) begin
        if (3'(i) <= held_count_i && cand[i] != xeu_pkg::ENT_TEXT[e][i]) begin
          ent_match[e] = 1'b0;
        end
      end
      ent_full[e] = ent_match[e] && (cand_len == xeu_pkg::ENT_LEN[e]);
    end
  end

  always_comb begin
    repl = 8'h00;
    for (int e = 0; e < xeu_pkg::NUM_ENT; e++) begin
      if (ent_full[e]) begin
        repl = xeu_pkg::ENT_REPL[e];
      end
    end
  end

  assign any_full = |ent_full;
  assign extend   = !any_full && (|ent_match) &&
                    (held_count_i < 3'(xeu_pkg::HOLD_MAX));

  // Results and next held state
  always_comb begin
    dec_o            = '0;
    dec_o.held_bytes = held_bytes_i;
    dec_o.res_bytes  = cand;
    priority if (any_full) begin
      dec_o.res_bytes[0] = repl;
      dec_o.res_count    = 3'd1;
      dec_o.held_count   = 3'd0;
    end else if (extend) begin
      for (int i = 0; i < xeu_pkg::HOLD_MAX; i++) begin
        dec_o.held_bytes[i] = cand[i];
      end
      // at end of text the extended prefix is flushed as it stands
      dec_o.res_count  = eot_i ? cand_len[2:0] : 3'd0;
      dec_o.held_count = eot_i ? 3'd0 : cand_len[2:0];
    end else begin
      // failed match: held bytes go out, new byte follows or reopens a match
      if (in_byte_i == xeu_pkg::AMP && !eot_i) begin
        dec_o.held_bytes[0] = xeu_pkg::AMP;
        dec_o.res_count     = held_count_i;
        dec_o.held_count    = 3'd1;
      end else begin
        dec_o.res_count  = cand_len[2:0];
        dec_o.held_count = 3'd0;
      end
    end
  end

endmodule

// ===== hdl/xml_entity_unescape.sv =====
// XML predefined entity decoder: top level with held prefix and result buffer.
// Depends on xeu_pkg, the xeu_in_if / xeu_out_if interfaces and xeu_decode.
//
// Usage:
//   in_i  carries escaped text, one byte per request, end_of_text on the last.
//   out_o carries decoded bytes; run_last marks the last result of a request,
//   text_done the final byte of the whole text.
//   &lt; &gt; &amp; &quot; &apos; become < > & " '; other bytes pass through.
// Timing:
//   A request is decoded in the cycle it is accepted and its results land in
//   a six-entry result register; the first result shows in the cycle after.
//   Results drain one per cycle while out_o.ready is high. A request yields
//   one to six results, or none when it only extends a pending match. A new
//   request is accepted when the result register is empty or its last entry
//   is taken in the same cycle, giving one byte per cycle for plain text
//   while out_o.ready stays high.
// Reset: clears the held prefix count and the result count; out_o.valid is low.
// Stall: while out_o.ready is low the current result holds, and in_i.ready
//   stays low for as long as the result register holds any result.
module xml_entity_unescape (
  input  logic        clk_i,
  input  logic        rst_ni,
  xeu_in_if.sink      in_i,
  xeu_out_if.source   out_o
);

  logic [2:0]                        held_count_q, held_count_d;
  logic [xeu_pkg::HOLD_MAX-1:0][7:0] held_bytes_q, held_bytes_d;
  logic [xeu_pkg::RES_MAX-1:0][7:0]  res_q, res_d;
  logic [2:0]                        cnt_q, cnt_d;
  logic [2:0]                        rd_q, rd_d;
  logic                              eot_q, eot_d;

  xeu_pkg::dec_t dec;
  logic          in_acc;
  logic          out_acc;
  logic          res_last;

  xeu_decode u_decode (
    .held_count_i (held_count_q),
    .held_bytes_i (held_bytes_q),
    .in_byte_i    (in_i.in_byte),
    .eot_i        (in_i.end_of_text),
    .dec_o        (dec)
  );

  // Output side of the result register
  assign res_last        = (rd_q == cnt_q - 3'd1);
  assign out_o.valid     = (cnt_q != 3'd0);
  assign out_o.out_byte  = res_q[rd_q];
  assign out_o.run_last  = res_last;
  assign out_o.text_done = res_last && eot_q;
  assign out_acc         = out_o.valid && out_o.ready;

  // Take a request when the buffer is empty or empties this cycle
  assign in_i.ready = (cnt_q == 3'd0) || (out_acc && res_last);
  assign in_acc     = in_i.valid && in_i.ready;

  // Next state for the held prefix and result register
  always_comb begin
    held_count_d = held_count_q;
    held_bytes_d = held_bytes_q;
    res_d        = res_q;
    cnt_d        = cnt_q;
    rd_d         = rd_q;
    eot_d        = eot_q;
    if (out_acc) begin
      if (res_last) begin
        cnt_d = 3'd0;
        rd_d  = 3'd0;
      end else begin
        rd_d = rd_q + 3'd1;
      end
    end
    if (in_acc) begin
      held_count_d = dec.held_count;
      held_bytes_d = dec.held_bytes;
      res_d        = dec.res_bytes;
      cnt_d        = dec.res_count;
      rd_d         = 3'd0;
      eot_d        = in_i.end_of_text;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count_q <= 3'd0;
      cnt_q        <= 3'd0;
      rd_q         <= 3'd0;
      eot_q        <= 1'b0;
    end else begin
      held_count_q <= held_count_d;
      cnt_q        <= cnt_d;
      rd_q         <= rd_d;
      eot_q        <= eot_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    held_bytes_q <= held_bytes_d;
    res_q        <= res_d;
  end

endmodule

// ===== tb/sv/xeu_tb_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard for the XML entity unescaper: predicts decoded bytes and checks them.
// Depends on xeu_pkg for the ampersand code and the longest held prefix.
package xeu_tb_pkg;

  // One decoded byte as it should leave the block
  typedef struct {
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_done;
  } decoded_t;

  typedef enum int {NO_MATCH, PREFIX, FULL} match_e;

  class unescape_scoreboard;
    string       spelling[5];
    logic [7:0]  replacement[5];
    logic [7:0]  held[xeu_pkg::HOLD_MAX+1];
    int unsigned held_n;
    decoded_t    expected_q[$];
    int unsigned n_requests;
    int unsigned n_results;
    int unsigned n_entities;
    int unsigned n_texts;
    int unsigned n_errors;

    function new();
      spelling    = '{"&lt;", "&gt;", "&amp;", "&quot;", "&apos;"};
      replacement = '{8'h3c, 8'h3e, 8'h26, 8'h22, 8'h27};
      held_n      = 0;
      n_requests  = 0;
      n_results   = 0;
      n_entities  = 0;
      n_texts     = 0;
      n_errors    = 0;
    endfunction

    // Classify the first n held bytes against every entity spelling
    function match_e classify(int unsigned n, output logic [7:0] repl);
      match_e kind;
      bit     same;
      kind = NO_MATCH;
      repl = 8'h00;
      foreach (spelling[e]) begin
        if (n <= spelling[e].len()) begin
          same = 1'b1;
          for (int i = 0; i < n; i++) begin
            if (held[i] != spelling[e][i]) same = 1'b0;
          end
          if (same && n == spelling[e].len()) begin
            repl = replacement[e];
            return FULL;
          end
          if (same) kind = PREFIX;
        end
      end
      return kind;
    endfunction

    // Advance the predicted decoder by one accepted request
    function void accept_escaped(logic [7:0] c, logic eot);
      logic [7:0] decoded[$];
      logic [7:0] repl;
      match_e     kind;
      decoded_t   d;
      n_requests++;
      if (held_n == 0) begin
        if (c == xeu_pkg::AMP) begin
          held[0] = c;
          held_n  = 1;
        end else begin
          decoded = {decoded, c};
        end
      end else begin
        held[held_n] = c;
        kind = classify(held_n + 1, repl);
        if (kind == FULL) begin
          held_n = 0;
          decoded = {decoded, repl};
          n_entities++;
        end else if (kind == PREFIX && held_n < xeu_pkg::HOLD_MAX) begin
          held_n++;
        end else begin
          // broken match: old prefix goes out, current byte handled afresh
          for (int i = 0; i < held_n; i++) decoded = {decoded, held[i]};
          if (c == xeu_pkg::AMP) begin
            held[0] = c;
            held_n  = 1;
          end else begin
            held_n = 0;
            decoded = {decoded, c};
          end
        end
      end
      // end of text flushes whatever is still pending
      if (eot) begin
        for (int i = 0; i < held_n; i++) decoded = {decoded, held[i]};
        held_n = 0;
        n_texts++;
      end
      foreach (decoded[i]) begin
        d.out_byte  = decoded[i];
        d.run_last  = (i == decoded.size() - 1);
        d.text_done = eot && d.run_last;
        expected_q  = {expected_q, d};
      end
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_decoded(logic [7:0] b, logic rl, logic td);
      decoded_t want;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: out_byte=%02h run_last=%0b text_done=%0b",
               b, rl, td);
        n_errors++;
        return;
      end
      want = expected_q.pop_front();
      n_results++;
      if (b !== want.out_byte) begin
        $error("out_byte: expected %02h, got %02h", want.out_byte, b);
        n_errors++;
      end
      if (rl !== want.run_last) begin
        $error("run_last: expected %0b, got %0b", want.run_last, rl);
        n_errors++;
      end
      if (td !== want.text_done) begin
        $error("text_done: expected %0b, got %0b", want.text_done, td);
        n_errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Top level testbench for xml_entity_unescape: directed and random escaped text,
// random stalls on both sides. Depends on xeu_pkg, the stream interfaces and xeu_tb_pkg.
module testbench;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned STALL_MAX    = 12;
  localparam int unsigned HOLD_OFF     = 300;  // long receiver stall, in cycles
  localparam int unsigned HOLD_OFF_AT  = 40;   // results taken before it starts
  localparam int unsigned RANDOM_ITEMS = 350;
  localparam int unsigned DRAIN_CYCLES = 20;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned random_sent = 0;
  bit          sender_no_gaps = 1'b0;
  string       ent_words[5] = '{"&lt;", "&gt;", "&amp;", "&quot;", "&apos;"};

  xeu_tb_pkg::unescape_scoreboard sb = new();

  xeu_in_if  in_if ();
  xeu_out_if out_if ();

  xml_entity_unescape uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #4 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("xml_entity_unescape regression: fail");
      $finish;
    end
  end

  // Offer one request after a random gap and wait for it to be taken
  task automatic send_byte(logic [7:0] b, logic eot);
    int unsigned gap;
    gap = sender_no_gaps ? 0 : $urandom_range(STALL_MAX, 0);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.in_byte     <= b;
    in_if.end_of_text <= eot;
    do @(posedge clk_i); while (!in_if.ready);
    sb.accept_escaped(b, eot);
  endtask

  task automatic send_text(string s, logic eot_last);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], eot_last && (i == s.len() - 1));
  endtask

  // Random text: mostly entities and near misses, with noise in between
  task automatic send_random_text();
    logic [7:0]  text_q[$];
    int unsigned pieces;
    int unsigned e;
    int unsigned cut;
    pieces = $urandom_range(10, 1);
    repeat (pieces) begin
      e = $urandom_range(4, 0);
      case ($urandom_range(9, 0))
        0, 1, 2, 3: begin
          for (int j = 0; j < ent_words[e].len(); j++) text_q = {text_q, ent_words[e][j]};
        end
        4, 5: begin
          // truncated entity followed by an arbitrary byte
          cut = $urandom_range(ent_words[e].len() - 1, 2);
          for (int j = 0; j < cut; j++) text_q = {text_q, ent_words[e][j]};
          text_q = {text_q, 8'($urandom_range(255, 0))};
        end
        6: text_q = {text_q, xeu_pkg::AMP};
        7: text_q = {text_q, 8'($urandom_range(255, 0))};
        default: begin
          repeat ($urandom_range(4, 1)) text_q = {text_q, 8'($urandom_range(8'h7e, 8'h20))};
        end
      endcase
    end
    sender_no_gaps = ($urandom_range(3, 0) == 0);
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
    random_sent += text_q.size();
  endtask

  // Result side: random stalls, one long hold-off to fill the block
  initial begin : drain_results
    int unsigned stall;
    int unsigned taken;
    bit          fast;
    taken = 0;
    fast  = 1'b0;
    out_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      if (taken % 50 == 0) fast = ($urandom_range(3, 0) == 0);
      stall = fast ? 0 : $urandom_range(STALL_MAX, 0);
      if (taken == HOLD_OFF_AT) stall = HOLD_OFF;
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      sb.check_decoded(out_if.out_byte, out_if.run_last, out_if.text_done);
      taken++;
    end
  end

  // Reset, stimulus and end of run
  initial begin
    in_if.valid       <= 1'b0;
    in_if.in_byte     <= 8'h00;
    in_if.end_of_text <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: byte extremes, an entity, longest failing match, flushes at end
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_text("&lt;", 1'b0);
    send_text("&aposx", 1'b0);
    send_text("&quot&", 1'b1);
    send_text("&a", 1'b1);
    send_text("&", 1'b1);

    while (random_sent < RANDOM_ITEMS) send_random_text();
    in_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d texts in %0d requests; %0d decoded bytes checked, %0d entities.",
             sb.n_texts, sb.n_requests, sb.n_results, sb.n_entities);
    if (sb.n_errors == 0) begin
      $display("xml_entity_unescape regression: pass");
    end else begin
      $display("xml_entity_unescape regression: fail");
    end
    $finish;
  end

endmodule
